// ----- src/swfs_pkg.sv -----
// swfs_pkg: types and constants shared by the stop-and-wait file sender
// no dependencies; compiled first
package swfs_pkg;

  localparam int unsigned FILE_SIZE_W = 24;
  localparam int unsigned RETRY_W     = 4;
  localparam int unsigned BLOCK_W     = 16;
  localparam int unsigned BYTES_W     = 9;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES = 9'd500;

  // file_size / 500 == (file_size >> 2) / 125, done as a reciprocal multiply
  localparam int unsigned RECIP_PRE   = 2;
  localparam int unsigned RECIP_IN_W  = FILE_SIZE_W - RECIP_PRE;
  localparam int unsigned RECIP_MUL_W = 23;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned RECIP_PROD_W = RECIP_IN_W + RECIP_MUL_W;
  localparam logic [RECIP_MUL_W-1:0] RECIP_MUL = 23'd4294968;

  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd10;

  localparam logic CFG_FILE_SIZE   = 1'b0;
  localparam logic CFG_MAX_RETRIES = 1'b1;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_ACK     = 3'd1;
  localparam logic [2:0] CMD_ERROR   = 3'd2;
  localparam logic [2:0] CMD_TIMEOUT = 3'd3;

  localparam logic [15:0] ERR_BUSY   = 16'd1;
  localparam logic [15:0] ERR_EXISTS = 16'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REQ,
    PH_XFER,
    PH_STOP
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_REQUEST  = 4'd1,
    ACT_DATA     = 4'd2,
    ACT_RESEND   = 4'd3,
    ACT_COMPLETE = 4'd4,
    ACT_NOREPLY  = 4'd5,
    ACT_RETRIES  = 4'd6,
    ACT_BUSY     = 4'd7,
    ACT_EXISTS   = 4'd8,
    ACT_UNKNOWN  = 4'd9
  } action_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] ack_block;
    logic [15:0] error_code;
  } in_item_t;

  typedef struct packed {
    action_t             action;
    logic [BLOCK_W-1:0]  block_number;
    logic [BYTES_W-1:0]  byte_count;
    logic [15:0]         packets_sent;
    logic                finished;
  } out_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] full_blocks;
    logic [BYTES_W-1:0] tail_bytes;
  } split_t;

endpackage

// ----- src/swfs_stream_if.sv -----
// swfs_stream_if: valid/ready channel carrying one payload per transaction
// payload type is set by the instantiating module
interface swfs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/stop_and_wait_file_sender.sv -----
// stop_and_wait_file_sender: top level, input register, core and result register
// depends on swfs_pkg, swfs_stream_if, swfs_split, swfs_core
//
//   port      dir   transaction
//   in_ch     sink  one event: cmd, ack_block, error_code
//   out_ch    src   one action per event: action, block, bytes, count, finished
//   cfg_*     in    register write on cfg_we, no read-back
//
// one event per cycle sustained while out_ch.ready stays high
// the event is latched, decoded by the state machine and the result registered
// a stalled result holds the result register and one more event can be latched
// synchronous active-low reset; no clearing pass
module stop_and_wait_file_sender (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [swfs_pkg::FILE_SIZE_W-1:0]  cfg_data,
  swfs_stream_if.sink                       in_ch,
  swfs_stream_if.source                     out_ch
);

  logic                          s1_valid_r, s1_valid_nxt;
  swfs_pkg::in_item_t            s1_data_r;
  logic                          out_valid_r, out_valid_nxt;
  swfs_pkg::out_item_t           out_data_r;
  logic                          advance;
  logic                          fire;
  logic                          in_take;
  logic [swfs_pkg::RETRY_W-1:0]  max_retries;
  swfs_pkg::split_t              split;
  swfs_pkg::out_item_t           result;

  swfs_split u_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .max_retries (max_retries),
    .split       (split)
  );

  swfs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_data_r),
    .max_retries (max_retries),
    .split       (split),
    .result      (result)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_ch.data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ----- src/swfs_split.sv -----
// swfs_split: configuration registers and the file size split into blocks
// depends on swfs_pkg
module swfs_split (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [swfs_pkg::FILE_SIZE_W-1:0]    cfg_data,
  output logic [swfs_pkg::RETRY_W-1:0]        max_retries,
  output swfs_pkg::split_t                    split
);

  logic [swfs_pkg::FILE_SIZE_W-1:0]  file_size_r;
  logic [swfs_pkg::RETRY_W-1:0]      max_retries_r;
  logic [swfs_pkg::BLOCK_W-1:0]      quot_r;
  logic [swfs_pkg::BLOCK_W-1:0]      quot_nxt;
  logic [swfs_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [swfs_pkg::BYTES_W-1:0]      quot_low_prod;

  // quotient is taken from the write data so it is ready with file_size_r
  assign recip_prod = swfs_pkg::RECIP_PROD_W'(cfg_data[swfs_pkg::FILE_SIZE_W-1:
                                                        swfs_pkg::RECIP_PRE])
                    * swfs_pkg::RECIP_PROD_W'(swfs_pkg::RECIP_MUL);
  assign quot_nxt   = recip_prod[swfs_pkg::RECIP_SHIFT +: swfs_pkg::BLOCK_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r   <= '0;
      max_retries_r <= swfs_pkg::MAX_RETRIES_RST;
      quot_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swfs_pkg::CFG_FILE_SIZE: begin
          file_size_r <= cfg_data;
          quot_r      <= quot_nxt;
        end
        swfs_pkg::CFG_MAX_RETRIES: begin
          max_retries_r <= cfg_data[swfs_pkg::RETRY_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // remainder only needs its low bits, since it is below one block
  assign quot_low_prod = swfs_pkg::BYTES_W'(quot_r[swfs_pkg::BYTES_W-1:0]
                                            * swfs_pkg::BLOCK_BYTES);

  assign split.full_blocks = quot_r;
  assign split.tail_bytes  = file_size_r[swfs_pkg::BYTES_W-1:0] - quot_low_prod;
  assign max_retries       = max_retries_r;

endmodule

// ----- src/swfs_core.sv -----
// swfs_core: transfer state machine, one event per enabled cycle
// depends on swfs_pkg; split values come from swfs_split
module swfs_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  swfs_pkg::in_item_t            item,
  input  logic [swfs_pkg::RETRY_W-1:0]  max_retries,
  input  swfs_pkg::split_t              split,
  output swfs_pkg::out_item_t           result
);

  swfs_pkg::phase_t                phase_r, phase_nxt;
  logic [swfs_pkg::BLOCK_W-1:0]    cur_blk_r, cur_blk_nxt;
  logic [swfs_pkg::RETRY_W-1:0]    retry_r, retry_nxt;
  logic [15:0]                     sent_r, sent_nxt;
  logic [swfs_pkg::BLOCK_W-1:0]    full_r, full_nxt;
  logic [swfs_pkg::BYTES_W-1:0]    tail_r, tail_nxt;
  logic                            last_sent_r, last_sent_nxt;
  logic                            started_r, started_nxt;

  logic [swfs_pkg::BLOCK_W-1:0]    full_eff;
  logic [swfs_pkg::BYTES_W-1:0]    tail_eff;
  logic [swfs_pkg::BLOCK_W-1:0]    blk_inc;
  logic                            retry_path;
  logic                            count_pkt;
  swfs_pkg::action_t               act;
  logic [swfs_pkg::BLOCK_W-1:0]    blk;
  logic [swfs_pkg::BYTES_W-1:0]    bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= swfs_pkg::PH_IDLE;
      cur_blk_r   <= '0;
      retry_r     <= '0;
      sent_r      <= '0;
      full_r      <= '0;
      tail_r      <= '0;
      last_sent_r <= 1'b0;
      started_r   <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      cur_blk_r   <= cur_blk_nxt;
      retry_r     <= retry_nxt;
      sent_r      <= sent_nxt;
      full_r      <= full_nxt;
      tail_r      <= tail_nxt;
      last_sent_r <= last_sent_nxt;
      started_r   <= started_nxt;
    end
  end

  assign full_eff = started_r ? full_r : split.full_blocks;
  assign tail_eff = started_r ? tail_r : split.tail_bytes;
  assign blk_inc  = cur_blk_r + 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    cur_blk_nxt   = cur_blk_r;
    retry_nxt     = retry_r;
    full_nxt      = full_r;
    tail_nxt      = tail_r;
    last_sent_nxt = last_sent_r;
    started_nxt   = started_r;
    retry_path    = 1'b0;
    count_pkt     = 1'b0;
    act           = swfs_pkg::ACT_NONE;
    blk           = '0;
    bytes         = '0;

    unique case (phase_r) inside
      swfs_pkg::PH_IDLE: begin
        if (item.cmd == swfs_pkg::CMD_START) begin
          phase_nxt = swfs_pkg::PH_REQ;
          act       = swfs_pkg::ACT_REQUEST;
        end
      end
      swfs_pkg::PH_REQ, swfs_pkg::PH_XFER: begin
        unique case (item.cmd)
          swfs_pkg::CMD_ACK: begin
            phase_nxt = swfs_pkg::PH_XFER;
            if (!started_r) begin
              full_nxt    = split.full_blocks;
              tail_nxt    = split.tail_bytes;
              started_nxt = 1'b1;
            end
            if (item.ack_block == cur_blk_r) begin
              if (last_sent_r) begin
                phase_nxt = swfs_pkg::PH_STOP;
                act       = swfs_pkg::ACT_COMPLETE;
              end else begin
                cur_blk_nxt = blk_inc;
                if (blk_inc <= full_eff) begin
                  bytes = swfs_pkg::BLOCK_BYTES;
                  if (tail_eff == '0 && blk_inc == full_eff) begin
                    last_sent_nxt = 1'b1;
                  end
                end else begin
                  bytes         = tail_eff;
                  last_sent_nxt = 1'b1;
                end
                blk       = blk_inc;
                retry_nxt = '0;
                count_pkt = 1'b1;
                act       = swfs_pkg::ACT_DATA;
              end
            end else begin
              retry_path = 1'b1;
            end
          end
          swfs_pkg::CMD_ERROR: begin
            phase_nxt = swfs_pkg::PH_STOP;
            if (item.error_code == swfs_pkg::ERR_BUSY) begin
              act = swfs_pkg::ACT_BUSY;
            end else if (item.error_code == swfs_pkg::ERR_EXISTS) begin
              act = swfs_pkg::ACT_EXISTS;
            end else begin
              act = swfs_pkg::ACT_UNKNOWN;
            end
          end
          swfs_pkg::CMD_TIMEOUT: begin
            if (phase_r == swfs_pkg::PH_REQ) begin
              phase_nxt = swfs_pkg::PH_STOP;
              act       = swfs_pkg::ACT_NOREPLY;
            end else begin
              retry_path = 1'b1;
            end
          end
          default: ;
        endcase

        // resend the held packet or give up
        if (retry_path) begin
          if (retry_r >= max_retries) begin
            phase_nxt = swfs_pkg::PH_STOP;
            act       = swfs_pkg::ACT_RETRIES;
          end else begin
            retry_nxt = retry_r + 4'd1;
            count_pkt = 1'b1;
            act       = swfs_pkg::ACT_RESEND;
          end
        end
      end
      swfs_pkg::PH_STOP: ;
      default: ;
    endcase

    sent_nxt = (count_pkt && sent_r != 16'hFFFF) ? sent_r + 16'd1 : sent_r;

    result.action       = act;
    result.block_number = blk;
    result.byte_count   = bytes;
    result.packets_sent = sent_nxt;
    result.finished     = (phase_nxt == swfs_pkg::PH_STOP);
  end

endmodule

// ----- test/tb_stop_and_wait_file_sender.sv -----
// tb_stop_and_wait_file_sender: self-checking bench for the stop-and-wait file sender
// drives events through swfs_stream_if, predicts each action and compares it
// depends on swfs_pkg, swfs_stream_if and stop_and_wait_file_sender
module tb_stop_and_wait_file_sender;

  localparam int BLOCK_SIZE     = 500;
  localparam int SUBPHASES      = 6;
  localparam int SUBPHASE_ITEMS = 100;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_REPORTS    = 10;

  localparam logic [2:0] CMD_OTHER = 3'd4;
  localparam logic [2:0] CMD_TOP   = 3'd7;

  typedef enum int {END_COMPLETE, END_RETRIES, END_BUSY, END_EXISTS, END_UNKNOWN} ending_t;
  typedef enum int {RX_ALWAYS, RX_TOGGLE, RX_COIN, RX_SPARSE} rx_pattern_t;

  typedef struct packed {
    swfs_pkg::phase_t phase;
    logic [15:0]   cur_block;
    logic [3:0]    retries_used;
    logic [15:0]   packets;
    logic [15:0]   full_blocks;
    logic [8:0]    tail;
    logic          last_sent;
    logic          data_started;
    logic [23:0]   file_size;
    logic [3:0]    max_retries;
  } sender_state_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;

  swfs_stream_if #(.payload_t(swfs_pkg::in_item_t))  in_ch ();
  swfs_stream_if #(.payload_t(swfs_pkg::out_item_t)) out_ch ();

  stop_and_wait_file_sender DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sender_state_t       sender_now;
  sender_state_t       sender_planned;
  swfs_pkg::in_item_t  pending_events[$];
  swfs_pkg::out_item_t expected_actions[$];
  swfs_pkg::out_item_t want;
  swfs_pkg::out_item_t got;
  logic          in_taken = 1'b0;
  logic          holding_off = 1'b0;
  int            accepted_events = 0;
  int            results_seen = 0;
  int            data_packets = 0;
  int            fail_count = 0;
  int            gap_left = 0;
  int            burst_left = 0;
  int            stall_left = 0;
  rx_pattern_t   stall_mode = RX_ALWAYS;
  logic          ready_next;
  ending_t       ending;
  string         ending_label;
  int            file_bytes;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic sender_state_t reset_state();
    sender_state_t s;
    s = '0;
    s.phase = swfs_pkg::PH_IDLE;
    s.max_retries = swfs_pkg::MAX_RETRIES_RST;
    return s;
  endfunction

  function automatic swfs_pkg::action_t resend_or_abort(inout sender_state_t s);
    if (s.retries_used >= s.max_retries) begin
      s.phase = swfs_pkg::PH_STOP;
      return swfs_pkg::ACT_RETRIES;
    end
    s.retries_used = s.retries_used + 4'd1;
    if (s.packets != 16'hFFFF) s.packets = s.packets + 16'd1;
    return swfs_pkg::ACT_RESEND;
  endfunction

  function automatic swfs_pkg::out_item_t next_action(inout sender_state_t s,
                                                      input swfs_pkg::in_item_t ev);
    swfs_pkg::out_item_t r;
    logic [31:0] quot;
    logic [31:0] rem;
    r = '0;
    r.action = swfs_pkg::ACT_NONE;
    case (s.phase) inside
      swfs_pkg::PH_IDLE: begin
        if (ev.cmd == swfs_pkg::CMD_START) begin
          s.phase = swfs_pkg::PH_REQ;
          r.action = swfs_pkg::ACT_REQUEST;
        end
      end
      swfs_pkg::PH_REQ, swfs_pkg::PH_XFER: begin
        if (ev.cmd == swfs_pkg::CMD_ACK) begin
          s.phase = swfs_pkg::PH_XFER;
          if (!s.data_started) begin
            quot = s.file_size / BLOCK_SIZE;
            rem = s.file_size % BLOCK_SIZE;
            s.full_blocks = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
            s.tail = rem[8:0];
            s.data_started = 1'b1;
          end
          if (ev.ack_block == s.cur_block) begin
            if (s.last_sent) begin
              s.phase = swfs_pkg::PH_STOP;
              r.action = swfs_pkg::ACT_COMPLETE;
            end else begin
              s.cur_block = s.cur_block + 16'd1;
              if (s.cur_block <= s.full_blocks) begin
                r.byte_count = 9'(BLOCK_SIZE);
                if (s.tail == 9'd0 && s.cur_block == s.full_blocks) s.last_sent = 1'b1;
              end else begin
                r.byte_count = s.tail;
                s.last_sent = 1'b1;
              end
              r.block_number = s.cur_block;
              s.retries_used = 4'd0;
              if (s.packets != 16'hFFFF) s.packets = s.packets + 16'd1;
              r.action = swfs_pkg::ACT_DATA;
            end
          end else begin
            r.action = resend_or_abort(s);
          end
        end else if (ev.cmd == swfs_pkg::CMD_ERROR) begin
          s.phase = swfs_pkg::PH_STOP;
          if (ev.error_code == swfs_pkg::ERR_BUSY) r.action = swfs_pkg::ACT_BUSY;
          else if (ev.error_code == swfs_pkg::ERR_EXISTS) r.action = swfs_pkg::ACT_EXISTS;
          else r.action = swfs_pkg::ACT_UNKNOWN;
        end else if (ev.cmd == swfs_pkg::CMD_TIMEOUT) begin
          if (s.phase == swfs_pkg::PH_REQ) begin
            s.phase = swfs_pkg::PH_STOP;
            r.action = swfs_pkg::ACT_NOREPLY;
          end else begin
            r.action = resend_or_abort(s);
          end
        end
      end
      default: ;
    endcase
    r.packets_sent = s.packets;
    r.finished = (s.phase == swfs_pkg::PH_STOP);
    return r;
  endfunction

  task automatic push_event(input logic [2:0] cmd, input logic [15:0] ack,
                            input logic [15:0] code);
    swfs_pkg::in_item_t ev;
    ev.cmd = cmd;
    ev.ack_block = ack;
    ev.error_code = code;
    void'(next_action(sender_planned, ev));
    pending_events.push_back(ev);
  endtask

  task automatic push_good_ack();
    push_event(swfs_pkg::CMD_ACK, sender_planned.cur_block, rand16());
  endtask

  // timeout, stale ack or a random wrong block number
  task automatic push_bad();
    logic [15:0] flip;
    flip = 16'($urandom_range(1, 16'hFFFF));
    case ($urandom_range(0, 2))
      0: push_event(swfs_pkg::CMD_TIMEOUT, rand16(), rand16());
      1: push_event(swfs_pkg::CMD_ACK, sender_planned.cur_block - 16'd1, rand16());
      default: push_event(swfs_pkg::CMD_ACK, sender_planned.cur_block ^ flip, rand16());
    endcase
  endtask

  task automatic push_noise();
    if ($urandom_range(0, 3) == 0) push_event(swfs_pkg::CMD_START, rand16(), rand16());
    else push_event(3'($urandom_range(CMD_OTHER, CMD_TOP)), rand16(), rand16());
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_ch.valid || expected_actions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == swfs_pkg::CFG_FILE_SIZE) begin
      sender_now.file_size = value;
      sender_planned.file_size = value;
    end else begin
      sender_now.max_retries = value[3:0];
      sender_planned.max_retries = value[3:0];
    end
  endtask

  // event driver, bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        in_ch.data <= pending_events.pop_front();
        in_ch.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, stall pattern changes every segment
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_pattern_t'($urandom_range(0, 3));
        stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (stall_mode)
        RX_ALWAYS: ready_next = 1'b1;
        RX_TOGGLE: ready_next = stall_left[0];
        RX_COIN:   ready_next = 1'($urandom_range(0, 1));
        default:   ready_next = ($urandom_range(0, 3) == 0);
      endcase
      out_ch.ready <= ready_next && !holding_off;
    end
  end

  // long receiver hold-off so the input backs up
  initial begin
    wait (accepted_events >= HOLD_AT);
    @(posedge clk);
    holding_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding_off = 1'b0;
  end

  // transaction monitor and checker
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_actions.push_back(next_action(sender_now, in_ch.data));
        accepted_events++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (got.action == swfs_pkg::ACT_DATA) data_packets++;
        if (expected_actions.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: act=%0d blk=%0d bytes=%0d sent=%0d fin=%0d",
                     got.action, got.block_number, got.byte_count, got.packets_sent,
                     got.finished);
        end else begin
          want = expected_actions.pop_front();
          if (got.action !== want.action || got.block_number !== want.block_number ||
              got.byte_count !== want.byte_count || got.packets_sent !== want.packets_sent ||
              got.finished !== want.finished) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch at result %0d: expected act=%0d blk=%0d bytes=%0d sent=%0d fin=%0d",
                       results_seen, want.action, want.block_number, want.byte_count,
                       want.packets_sent, want.finished);
              $display("  got act=%0d blk=%0d bytes=%0d sent=%0d fin=%0d",
                       got.action, got.block_number, got.byte_count, got.packets_sent,
                       got.finished);
            end
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          n_blocks;
    int          tail_len;
    int          phase_items;
    int          pick;
    logic [15:0] code;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sender_now = reset_state();
    sender_planned = reset_state();

    pick = $urandom_range(0, 9);
    if (pick < 4) ending = END_COMPLETE;
    else if (pick < 6) ending = END_RETRIES;
    else if (pick < 7) ending = END_BUSY;
    else if (pick < 8) ending = END_EXISTS;
    else ending = END_UNKNOWN;
    // a completing transfer ends near the close of the random part, an aborted one must not
    n_blocks = (ending == END_COMPLETE) ? $urandom_range(380, 440) : $urandom_range(700, 900);
    tail_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, BLOCK_SIZE - 1);
    file_bytes = n_blocks * BLOCK_SIZE + tail_len;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // events before start are ignored
    push_event(swfs_pkg::CMD_ACK, 16'h0000, 16'h0000);
    push_event(swfs_pkg::CMD_ACK, 16'hFFFF, 16'hFFFF);
    push_event(swfs_pkg::CMD_ERROR, rand16(), swfs_pkg::ERR_BUSY);
    push_event(swfs_pkg::CMD_ERROR, 16'h0000, 16'hFFFF);
    push_event(swfs_pkg::CMD_TIMEOUT, rand16(), rand16());
    push_event(CMD_OTHER, rand16(), rand16());
    push_event(3'd5, rand16(), rand16());
    push_event(3'd6, rand16(), rand16());
    push_event(CMD_TOP, rand16(), rand16());
    wait_idle();
    set_reg(swfs_pkg::CFG_FILE_SIZE, 24'(file_bytes));
    set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'd15);

    // start, request resent on wrong acks, first blocks with a timeout and a stale ack
    push_event(swfs_pkg::CMD_START, 16'h0000, 16'h0000);
    push_event(swfs_pkg::CMD_START, 16'hFFFF, 16'hFFFF);
    push_event(CMD_OTHER, rand16(), rand16());
    push_event(swfs_pkg::CMD_ACK, 16'd3, 16'h0000);
    push_event(swfs_pkg::CMD_ACK, 16'hFFFF, 16'h0000);
    push_event(CMD_TOP, rand16(), rand16());
    push_good_ack();
    push_event(swfs_pkg::CMD_TIMEOUT, 16'h0000, 16'h0000);
    push_event(swfs_pkg::CMD_ACK, 16'd0, 16'h0000);
    push_good_ack();
    push_event(swfs_pkg::CMD_START, rand16(), rand16());
    push_good_ack();

    for (int sp = 0; sp < SUBPHASES; sp++) begin
      wait_idle();
      case (sp)
        1: begin
          set_reg(swfs_pkg::CFG_FILE_SIZE, 24'hFFFFFF);
          set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'($urandom_range(1, 14)));
        end
        2: begin
          set_reg(swfs_pkg::CFG_FILE_SIZE, 24'h000000);
          set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'd0);
        end
        3: set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'd15);
        4: set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'($urandom_range(0, 15)));
        5: set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'($urandom_range(2, 15)));
        default: ;
      endcase
      phase_items = 0;
      while (phase_items < SUBPHASE_ITEMS && sender_planned.phase != swfs_pkg::PH_STOP) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          push_noise();
        end else begin
          if (pick < 22 && sender_planned.retries_used < sender_planned.max_retries) begin
            push_bad();
          end else if (pick < 24 &&
                       sender_planned.retries_used < sender_planned.max_retries) begin
            // use up every resend without aborting
            while (sender_planned.retries_used < sender_planned.max_retries) push_bad();
          end else begin
            push_good_ack();
          end
          phase_items++;
        end
      end
    end

    wait_idle();
    case (ending)
      END_COMPLETE: begin
        ending_label = "completion";
        while (sender_planned.phase != swfs_pkg::PH_STOP) push_good_ack();
      end
      END_RETRIES: begin
        ending_label = "resends used up";
        set_reg(swfs_pkg::CFG_MAX_RETRIES, 24'($urandom_range(0, 3)));
        while (sender_planned.phase != swfs_pkg::PH_STOP) push_bad();
      end
      END_BUSY: begin
        ending_label = "server busy";
        push_event(swfs_pkg::CMD_ERROR, rand16(), swfs_pkg::ERR_BUSY);
      end
      END_EXISTS: begin
        ending_label = "file exists";
        push_event(swfs_pkg::CMD_ERROR, rand16(), swfs_pkg::ERR_EXISTS);
      end
      default: begin
        ending_label = "unknown server error";
        do code = rand16(); while (code == swfs_pkg::ERR_BUSY || code == swfs_pkg::ERR_EXISTS);
        push_event(swfs_pkg::CMD_ERROR, rand16(), code);
      end
    endcase

    // stopped: everything is ignored
    push_event(swfs_pkg::CMD_START, rand16(), rand16());
    push_good_ack();
    push_event(swfs_pkg::CMD_ERROR, rand16(), swfs_pkg::ERR_BUSY);
    push_event(swfs_pkg::CMD_TIMEOUT, rand16(), rand16());
    push_event(CMD_OTHER, rand16(), rand16());
    push_event(CMD_TOP, rand16(), rand16());

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run: %0d events in, %0d actions out, %0d data packets, %0d failures",
             accepted_events, results_seen, data_packets, fail_count);
    $display("transfer of %0d bytes ended by %s", file_bytes, ending_label);
    if (fail_count == 0 && expected_actions.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
